/* rtl/bbl_pkg.sv */
`default_nettype none
package bbl_pkg;

  localparam int unsigned DimW   = 16;
  localparam int unsigned IdW    = 31;
  localparam int unsigned BytesW = 40;
  localparam int unsigned PinsW  = 16;

  localparam logic [1:0] CmdGet     = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdDirty   = 2'd2;

  localparam logic [2:0] StHit    = 3'd0;
  localparam logic [2:0] StMiss   = 3'd1;
  localparam logic [2:0] StEvict  = 3'd2;
  localparam logic [2:0] StDone   = 3'd3;
  localparam logic [2:0] StReject = 3'd4;

  localparam logic [BytesW-1:0] BudgetReset = 40'd1073741824;

  typedef struct packed {
    logic [DimW-1:0]   dim;
    logic [IdW-1:0]    id;
    logic [BytesW-1:0] size;
    logic [PinsW-1:0]  pins;
    logic              dirty;
  } entry_t;

  typedef struct packed {
    logic       accept;
    logic       scan_start;
    logic       hit;
    logic       release_op;
    logic       mark;
    logic       evict;
    logic       insert;
    logic       ins_old;
    logic       emit;
    logic       emit_old;
    logic       emit_last;
    logic [2:0] emit_code;
  } dp_cmd_t;

  typedef struct packed {
    logic       scan_done;
    logic       match;
    logic       free;
    logic       old;
    logic       over;
    logic       out_free;
    logic [1:0] cmd;
    logic       upd;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/byte_budget_lru_pinned_cache_policy_unit.sv */
// Pinned LRU cache policy with a byte budget. Commands (get, release, mark
// dirty) enter one at a time; each produces zero or more eviction notices
// followed by one final word flagged last. Every lookup is a scan of the
// entry table through its single read port, one entry per cycle, and while
// the bytes in use exceed the budget the table is scanned again for an entry
// to evict. The result register lets the next command be taken while the
// last word of the previous one still waits.
`default_nettype none
module byte_budget_lru_pinned_cache_policy_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire [1:0]   command_i,
  input  wire [15:0]  dimension_i,
  input  wire [30:0]  index_id_i,
  input  wire [39:0]  entry_bytes_i,
  input  wire         is_updated_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] key_dimension_o,
  output logic [30:0] key_index_id_o,
  output logic        writeback_o,
  output logic [39:0] bytes_in_use_o,
  output logic        over_budget_o,
  output logic        last_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [39:0]  cfg_byte_budget_i
);
  import bbl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready_o = 1'b1;

  bbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  bbl_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (st),
    .command_i         (command_i),
    .dimension_i       (dimension_i),
    .index_id_i        (index_id_i),
    .entry_bytes_i     (entry_bytes_i),
    .is_updated_i      (is_updated_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_byte_budget_i (cfg_byte_budget_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .res_status_o      (status_o),
    .key_dimension_o   (key_dimension_o),
    .key_index_id_o    (key_index_id_o),
    .writeback_o       (writeback_o),
    .bytes_in_use_o    (bytes_in_use_o),
    .over_budget_o     (over_budget_o),
    .last_o            (last_o)
  );

  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StEvict) |-> !last_o)
    else $error("eviction notice flagged last");

  a_wb_only_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && writeback_o) |-> (status_o == StEvict))
    else $error("writeback on a non-eviction word");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new command taken while one is in progress");

endmodule
`default_nettype wire

/* rtl/bbl_datapath.sv */
`default_nettype none
module bbl_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire bbl_pkg::dp_cmd_t cmd_i,
  output bbl_pkg::dp_status_t   status_o,
  input  wire [1:0]             command_i,
  input  wire [15:0]            dimension_i,
  input  wire [30:0]            index_id_i,
  input  wire [39:0]            entry_bytes_i,
  input  wire                   is_updated_i,
  input  wire                   cfg_valid_i,
  input  wire [39:0]            cfg_byte_budget_i,
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  output logic [2:0]            res_status_o,
  output logic [15:0]           key_dimension_o,
  output logic [30:0]           key_index_id_o,
  output logic                  writeback_o,
  output logic [39:0]           bytes_in_use_o,
  output logic                  over_budget_o,
  output logic                  last_o
);
  import bbl_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned TW = BytesW + IW;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  // request word
  logic [1:0]        cmd_q;
  logic [DimW-1:0]   dim_q;
  logic [IdW-1:0]    id_q;
  logic [BytesW-1:0] bytes_q;
  logic              upd_q;
  logic [BytesW-1:0] budget_q;
  logic [TW-1:0]     total_q, total_d;

  logic               valid_q [ENTRIES];
  logic [IW-1:0]      age_q   [ENTRIES];
  logic [$bits(entry_t)-1:0] mem [ENTRIES];

  // scan
  logic          busy_q, rd_v_q;
  logic [IW-1:0] ptr_q, rd_idx_q;
  entry_t        rdata_q;
  logic          match_q, free_q, old_q;
  logic [IW-1:0] match_idx_q, free_idx_q, old_idx_q, old_age_q;
  entry_t        match_w_q, old_w_q;

  logic          over;
  logic          out_free;
  logic          we;
  logic [IW-1:0] waddr, ins_idx;
  entry_t        wdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= command_i;
      dim_q   <= dimension_i;
      id_q    <= index_id_i;
      bytes_q <= entry_bytes_i;
      upd_q   <= is_updated_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BudgetReset;
    end else if (cfg_valid_i) begin
      budget_q <= cfg_byte_budget_i;
    end
  end

  assign ins_idx = cmd_i.ins_old ? old_idx_q : free_idx_q;

  always_comb begin
    total_d = total_q;
    if (cmd_i.insert) begin
      total_d = total_q + TW'(bytes_q);
    end else if (cmd_i.evict) begin
      total_d = total_q - TW'(old_w_q.size);
    end else if (cmd_i.release_op && upd_q) begin
      total_d = total_q - TW'(match_w_q.size) + TW'(bytes_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  assign over = total_q > TW'(budget_q);

  // valid bits and LRU ranks, one lane per entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) valid_q[i] <= 1'b0;
    end else if (cmd_i.evict) begin
      valid_q[old_idx_q] <= 1'b0;
    end else if (cmd_i.insert) begin
      valid_q[ins_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd_i.hit) begin
        if (IW'(i) == match_idx_q) age_q[i] <= '0;
        else if (valid_q[i] && age_q[i] < age_q[match_idx_q]) age_q[i] <= age_q[i] + 1'b1;
      end else if (cmd_i.evict) begin
        if (valid_q[i] && age_q[i] > old_age_q) age_q[i] <= age_q[i] - 1'b1;
      end else if (cmd_i.insert) begin
        if (IW'(i) == ins_idx) age_q[i] <= '0;
        else if (valid_q[i]) age_q[i] <= age_q[i] + 1'b1;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = match_idx_q;
    wdata = match_w_q;
    if (cmd_i.hit) begin
      we = 1'b1;
      if (match_w_q.pins != '1) wdata.pins = match_w_q.pins + 1'b1;
    end else if (cmd_i.release_op) begin
      we = 1'b1;
      if (match_w_q.pins != '0) wdata.pins = match_w_q.pins - 1'b1;
      if (upd_q) begin
        wdata.size  = bytes_q;
        wdata.dirty = 1'b1;
      end
    end else if (cmd_i.mark) begin
      we          = 1'b1;
      wdata.dirty = 1'b1;
    end else if (cmd_i.insert) begin
      we          = 1'b1;
      waddr       = ins_idx;
      wdata.dim   = dim_q;
      wdata.id    = id_q;
      wdata.size  = bytes_q;
      wdata.pins  = PinsW'(1);
      wdata.dirty = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= entry_t'(mem[ptr_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rd_v_q   <= 1'b0;
      ptr_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      rd_v_q   <= busy_q;
      rd_idx_q <= ptr_q;
      if (cmd_i.scan_start) begin
        busy_q <= 1'b1;
        ptr_q  <= '0;
      end else if (busy_q) begin
        if (ptr_q == LastIdx) begin
          busy_q <= 1'b0;
          ptr_q  <= '0;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
    end
  end

  // one entry compared per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      old_q   <= 1'b0;
    end else if (cmd_i.scan_start) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
      old_q   <= 1'b0;
    end else if (rd_v_q) begin
      if (!valid_q[rd_idx_q] && !free_q) free_q <= 1'b1;
      if (valid_q[rd_idx_q] && rdata_q.dim == dim_q && rdata_q.id == id_q) match_q <= 1'b1;
      if (valid_q[rd_idx_q] && rdata_q.pins == '0 &&
          (!old_q || age_q[rd_idx_q] > old_age_q)) old_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q && !cmd_i.scan_start) begin
      if (!valid_q[rd_idx_q] && !free_q) free_idx_q <= rd_idx_q;
      if (valid_q[rd_idx_q] && rdata_q.dim == dim_q && rdata_q.id == id_q) begin
        match_idx_q <= rd_idx_q;
        match_w_q   <= rdata_q;
      end
      if (valid_q[rd_idx_q] && rdata_q.pins == '0 &&
          (!old_q || age_q[rd_idx_q] > old_age_q)) begin
        old_idx_q <= rd_idx_q;
        old_age_q <= age_q[rd_idx_q];
        old_w_q   <= rdata_q;
      end
    end
  end

  // result register
  assign out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_status_o    <= cmd_i.emit_code;
      key_dimension_o <= cmd_i.emit_old ? old_w_q.dim : dim_q;
      key_index_id_o  <= cmd_i.emit_old ? old_w_q.id : id_q;
      writeback_o     <= cmd_i.emit_old & old_w_q.dirty;
      bytes_in_use_o  <= (|total_q[TW-1:BytesW]) ? '1 : total_q[BytesW-1:0];
      over_budget_o   <= over;
      last_o          <= cmd_i.emit_last;
    end
  end

  assign status_o.scan_done = rd_v_q && (rd_idx_q == LastIdx);
  assign status_o.match     = match_q;
  assign status_o.free      = free_q;
  assign status_o.old       = old_q;
  assign status_o.over      = over;
  assign status_o.out_free  = out_free;
  assign status_o.cmd       = cmd_q;
  assign status_o.upd       = upd_q;

endmodule
`default_nettype wire

/* rtl/bbl_ctrl.sv */
`default_nettype none
module bbl_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire bbl_pkg::dp_status_t status_i,
  output bbl_pkg::dp_cmd_t         cmd_o
);
  import bbl_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SScan   = 4'd1;
  localparam logic [3:0] SDecide = 4'd2;
  localparam logic [3:0] SEvEmit = 4'd3;
  localparam logic [3:0] SInsert = 4'd4;
  localparam logic [3:0] SCheck  = 4'd5;
  localparam logic [3:0] SRescan = 4'd6;
  localparam logic [3:0] SFinal  = 4'd7;
  localparam logic [3:0] SPick   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [2:0] fin_q, fin_d;
  logic       full_q, full_d;

  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    full_d     = full_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept     = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = SScan;
        end
      end
      SScan: begin
        if (status_i.scan_done) state_d = SDecide;
      end
      SDecide: begin
        fin_d   = StDone;
        state_d = SFinal;
        if (status_i.cmd == CmdGet) begin
          if (status_i.match) begin
            cmd_o.hit = 1'b1;
            fin_d     = StHit;
          end else if (status_i.free) begin
            cmd_o.insert = 1'b1;
            fin_d        = StMiss;
            state_d      = SCheck;
          end else if (status_i.old) begin
            // table full: make room first
            cmd_o.evict = 1'b1;
            fin_d       = StMiss;
            full_d      = 1'b1;
            state_d     = SEvEmit;
          end else begin
            fin_d = StReject;
          end
        end else if (status_i.cmd == CmdRelease && status_i.match) begin
          cmd_o.release_op = 1'b1;
          if (status_i.upd) state_d = SCheck;
        end else if (status_i.cmd == CmdDirty && status_i.match) begin
          cmd_o.mark = 1'b1;
        end
      end
      SEvEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_old  = 1'b1;
          cmd_o.emit_code = StEvict;
          state_d         = full_q ? SInsert : SCheck;
        end
      end
      SInsert: begin
        cmd_o.insert  = 1'b1;
        cmd_o.ins_old = 1'b1;
        full_d        = 1'b0;
        state_d       = SCheck;
      end
      SCheck: begin
        if (status_i.over) begin
          cmd_o.scan_start = 1'b1;
          state_d          = SRescan;
        end else begin
          state_d = SFinal;
        end
      end
      SRescan: begin
        // last entry's compare lands at this edge
        if (status_i.scan_done) state_d = SPick;
      end
      SPick: begin
        if (status_i.old) begin
          cmd_o.evict = 1'b1;
          state_d     = SEvEmit;
        end else begin
          state_d = SFinal;
        end
      end
      SFinal: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.emit_code = fin_q;
          state_d         = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      fin_q   <= StDone;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      full_q  <= full_d;
    end
  end

endmodule
`default_nettype wire
